>>> rtl/core/assert_macros.svh
// assertion shorthands used by ranked_score_table_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define RSTAB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// expression must never be true outside reset
`define RSTAB_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

>>> rtl/core/rstab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rstab_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int OP_W     = 2;
    localparam int ID_W     = 31;
    localparam int SCORE_W  = 16;
    localparam int RANK_W   = 9;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 9;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INSERT,
        ST_DELETE,
        ST_QUERY_RD,
        ST_QUERY_CAP,
        ST_FINISH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic ins_step;
        logic del_step;
        logic qry_read;
        logic qry_cap;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            rank_bad;
        logic            ins_done;
        logic            del_done;
    } sts_t;

    // held record stays ahead of the new one
    function automatic logic goes_before(input entry_t held, input logic [ID_W-1:0] id,
                                         input logic [SCORE_W-1:0] score);
        return (held.score > score) || ((held.score == score) && (held.id < id));
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rstab_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rstab_dp #(
    parameter int TABLE_DEPTH = rstab_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire rstab_pkg::cmd_t                 cmd,
    output rstab_pkg::sts_t                      sts,
    input  wire logic [rstab_pkg::OP_W-1:0]      s_op,
    input  wire logic [rstab_pkg::ID_W-1:0]      s_record_id,
    input  wire logic [rstab_pkg::SCORE_W-1:0]   s_record_score,
    input  wire logic [rstab_pkg::RANK_W-1:0]    s_query_rank,
    input  wire logic [rstab_pkg::SCORE_W-1:0]   s_key_score,
    output logic [rstab_pkg::STATUS_W-1:0]       m_status,
    output logic [rstab_pkg::ID_W-1:0]           m_found_id,
    output logic [rstab_pkg::SCORE_W-1:0]        m_found_score,
    output logic [rstab_pkg::TOTAL_W-1:0]        m_removed_count,
    output logic [rstab_pkg::TOTAL_W-1:0]        m_entry_total
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > rstab_pkg::RANK_W) ? CNT_W : rstab_pkg::RANK_W;

    rstab_pkg::entry_t table_mem [TABLE_DEPTH];
    rstab_pkg::entry_t rd_data_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    rstab_pkg::entry_t wr_data;

    logic [rstab_pkg::OP_W-1:0]    op_reg, op_next;
    logic [rstab_pkg::ID_W-1:0]    id_reg, id_next;
    logic [rstab_pkg::SCORE_W-1:0] score_reg, score_next;
    logic [rstab_pkg::RANK_W-1:0]  rank_reg, rank_next;
    logic [rstab_pkg::SCORE_W-1:0] key_reg, key_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  removed_reg, removed_next;
    logic              pv_reg, pv_next;
    logic [ADDR_W-1:0] pidx_reg, pidx_next;

    logic [rstab_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [rstab_pkg::ID_W-1:0]     res_id_reg, res_id_next;
    logic [rstab_pkg::SCORE_W-1:0]  res_score_reg, res_score_next;

    logic [rstab_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [rstab_pkg::ID_W-1:0]     m_found_id_reg, m_found_id_next;
    logic [rstab_pkg::SCORE_W-1:0]  m_found_score_reg, m_found_score_next;
    logic [rstab_pkg::TOTAL_W-1:0]  m_removed_reg, m_removed_next;
    logic [rstab_pkg::TOTAL_W-1:0]  m_total_reg, m_total_next;

    logic             ins_hit;
    logic             full;
    logic             rank_bad;
    logic [CMP_W-1:0] rank_ext;
    logic [CMP_W-1:0] count_ext;

    // status toward the controller
    assign rank_ext  = CMP_W'(rank_reg);
    assign count_ext = CMP_W'(count_reg);
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign rank_bad  = (rank_ext == '0) || (rank_ext > count_ext);
    assign ins_hit   = pv_reg && rstab_pkg::goes_before(rd_data_reg, id_reg, score_reg);

    always_comb begin
        sts.op       = op_reg;
        sts.full     = full;
        sts.rank_bad = rank_bad;
        sts.ins_done = ins_hit || (!pv_reg && (ptr_reg == '0));
        sts.del_done = !pv_reg && (ptr_reg == count_reg);
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '{id: id_reg, score: score_reg};

        op_next            = op_reg;
        id_next            = id_reg;
        score_next         = score_reg;
        rank_next          = rank_reg;
        key_next           = key_reg;
        count_next         = count_reg;
        ptr_next           = ptr_reg;
        wr_ptr_next        = wr_ptr_reg;
        removed_next       = removed_reg;
        pv_next            = pv_reg;
        pidx_next          = pidx_reg;
        res_status_next    = res_status_reg;
        res_id_next        = res_id_reg;
        res_score_next     = res_score_reg;
        m_status_next      = m_status_reg;
        m_found_id_next    = m_found_id_reg;
        m_found_score_next = m_found_score_reg;
        m_removed_next     = m_removed_reg;
        m_total_next       = m_total_reg;

        if (cmd.load) begin
            op_next    = s_op;
            id_next    = s_record_id;
            score_next = s_record_score;
            rank_next  = s_query_rank;
            key_next   = s_key_score;
        end

        if (cmd.start) begin
            pv_next        = 1'b0;
            ptr_next       = (op_reg == rstab_pkg::OP_DELETE) ? '0 : count_reg;
            wr_ptr_next    = '0;
            removed_next   = '0;
            res_id_next    = '0;
            res_score_next = '0;
            if ((op_reg == rstab_pkg::OP_INSERT) && full) begin
                res_status_next = rstab_pkg::STATUS_FULL;
            end else if ((op_reg == rstab_pkg::OP_QUERY) && rank_bad) begin
                res_status_next = rstab_pkg::STATUS_RANGE;
            end else begin
                res_status_next = rstab_pkg::STATUS_OK;
            end
        end

        // walk down from the tail, shifting each entry up one slot
        if (cmd.ins_step) begin
            if (pv_reg) begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(pidx_reg + ADDR_W'(1));
                if (!ins_hit) begin
                    wr_data = rd_data_reg;
                end
            end else if (ptr_reg == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end
            if (!sts.ins_done && (ptr_reg != '0)) begin
                rd_en     = 1'b1;
                rd_addr   = ADDR_W'(ptr_reg - CNT_W'(1));
                pv_next   = 1'b1;
                pidx_next = ADDR_W'(ptr_reg - CNT_W'(1));
                ptr_next  = ptr_reg - CNT_W'(1);
            end else begin
                pv_next = 1'b0;
            end
            if (sts.ins_done) begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        // forward compaction, write pointer trails the read pointer
        if (cmd.del_step) begin
            if (pv_reg) begin
                if (rd_data_reg.score == key_reg) begin
                    removed_next = removed_reg + CNT_W'(1);
                end else begin
                    wr_en       = 1'b1;
                    wr_addr     = ADDR_W'(wr_ptr_reg);
                    wr_data     = rd_data_reg;
                    wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                end
            end
            if (ptr_reg < count_reg) begin
                rd_en    = 1'b1;
                rd_addr  = ADDR_W'(ptr_reg);
                pv_next  = 1'b1;
                ptr_next = ptr_reg + CNT_W'(1);
            end else begin
                pv_next = 1'b0;
            end
            if (sts.del_done) begin
                count_next = wr_ptr_reg;
            end
        end

        if (cmd.qry_read) begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(rank_ext - CMP_W'(1));
        end

        if (cmd.qry_cap) begin
            res_id_next    = rd_data_reg.id;
            res_score_next = rd_data_reg.score;
        end

        if (cmd.out_load) begin
            m_status_next      = res_status_reg;
            m_found_id_next    = res_id_reg;
            m_found_score_next = res_score_reg;
            m_removed_next     = rstab_pkg::TOTAL_W'(removed_reg);
            m_total_next       = rstab_pkg::TOTAL_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pv_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg            <= op_next;
        id_reg            <= id_next;
        score_reg         <= score_next;
        rank_reg          <= rank_next;
        key_reg           <= key_next;
        ptr_reg           <= ptr_next;
        wr_ptr_reg        <= wr_ptr_next;
        removed_reg       <= removed_next;
        pidx_reg          <= pidx_next;
        res_status_reg    <= res_status_next;
        res_id_reg        <= res_id_next;
        res_score_reg     <= res_score_next;
        m_status_reg      <= m_status_next;
        m_found_id_reg    <= m_found_id_next;
        m_found_score_reg <= m_found_score_next;
        m_removed_reg     <= m_removed_next;
        m_total_reg       <= m_total_next;
    end

    assign m_status        = m_status_reg;
    assign m_found_id      = m_found_id_reg;
    assign m_found_score   = m_found_score_reg;
    assign m_removed_count = m_removed_reg;
    assign m_entry_total   = m_total_reg;

endmodule

`default_nettype wire

>>> rtl/core/rstab_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rstab_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire rstab_pkg::sts_t sts,
    output rstab_pkg::cmd_t      cmd
);

    rstab_pkg::ctrl_state_t state_reg, state_next;
    logic                   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rstab_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;

        unique case (state_reg)
            rstab_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = rstab_pkg::ST_DISPATCH;
                end
            end
            rstab_pkg::ST_DISPATCH: begin
                cmd.start = 1'b1;
                case (sts.op)
                    rstab_pkg::OP_INSERT: begin
                        state_next = sts.full ? rstab_pkg::ST_FINISH : rstab_pkg::ST_INSERT;
                    end
                    rstab_pkg::OP_QUERY: begin
                        state_next = sts.rank_bad ? rstab_pkg::ST_FINISH
                                                  : rstab_pkg::ST_QUERY_RD;
                    end
                    rstab_pkg::OP_DELETE: begin
                        state_next = rstab_pkg::ST_DELETE;
                    end
                    default: begin
                        state_next = rstab_pkg::ST_FINISH;
                    end
                endcase
            end
            rstab_pkg::ST_INSERT: begin
                cmd.ins_step = 1'b1;
                if (sts.ins_done) begin
                    state_next = rstab_pkg::ST_FINISH;
                end
            end
            rstab_pkg::ST_DELETE: begin
                cmd.del_step = 1'b1;
                if (sts.del_done) begin
                    state_next = rstab_pkg::ST_FINISH;
                end
            end
            rstab_pkg::ST_QUERY_RD: begin
                cmd.qry_read = 1'b1;
                state_next   = rstab_pkg::ST_QUERY_CAP;
            end
            rstab_pkg::ST_QUERY_CAP: begin
                cmd.qry_cap = 1'b1;
                state_next  = rstab_pkg::ST_FINISH;
            end
            rstab_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = rstab_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rstab_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/ranked_score_table_top.sv
// channel   dir  handshake          word fields
// s_        in   s_valid / s_ready  op, record_id, record_score, query_rank, key_score
// m_        out  m_valid / m_ready  status, found_id, found_score, removed_count, entry_total
//
// one word at a time; insert and delete times are set by the walk of one table entry per cycle
// insert walks from the tail shifting entries up one per cycle, delete compacts forward
// aresetn synchronous active low: empties the table (count to zero), no clearing pass
// the next word is accepted while a finished result still waits in the output register
// a stalled m_ready holds the result and parks the controller before its next load
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ranked_score_table_top #(
    parameter int TABLE_DEPTH = rstab_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input word channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [rstab_pkg::OP_W-1:0]      s_op,
    input  wire logic [rstab_pkg::ID_W-1:0]      s_record_id,
    input  wire logic [rstab_pkg::SCORE_W-1:0]   s_record_score,
    input  wire logic [rstab_pkg::RANK_W-1:0]    s_query_rank,
    input  wire logic [rstab_pkg::SCORE_W-1:0]   s_key_score,
    // result word channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [rstab_pkg::STATUS_W-1:0]       m_status,
    output logic [rstab_pkg::ID_W-1:0]           m_found_id,
    output logic [rstab_pkg::SCORE_W-1:0]        m_found_score,
    output logic [rstab_pkg::TOTAL_W-1:0]        m_removed_count,
    output logic [rstab_pkg::TOTAL_W-1:0]        m_entry_total
);

    // command and status between the sequencer and the table datapath
    rstab_pkg::cmd_t cmd;
    rstab_pkg::sts_t sts;

    // sequencer: accept, dispatch on op, step the walk, hand off the result
    rstab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // table memory, count, walk pointers and output register
    rstab_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_record_id     (s_record_id),
        .s_record_score  (s_record_score),
        .s_query_rank    (s_query_rank),
        .s_key_score     (s_key_score),
        .m_status        (m_status),
        .m_found_id      (m_found_id),
        .m_found_score   (m_found_score),
        .m_removed_count (m_removed_count),
        .m_entry_total   (m_entry_total)
    );

    // a new result only lands in a free or draining output register
    `RSTAB_ASSERT(a_out_slot_free, aclk, aresetn, cmd.out_load |-> (!m_valid || m_ready), "result overwrote a pending word")
    // only one word is in work at a time
    `RSTAB_ASSERT(a_single_item, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "second word accepted during work")
    // insert and delete walks never run together
    `RSTAB_NEVER(a_walk_excl, aclk, aresetn, cmd.ins_step && cmd.del_step, "insert and delete walk overlap")
    // dispatch always follows a capture of the input word
    `RSTAB_ASSERT(a_start_after_load, aclk, aresetn, cmd.start |-> $past(cmd.load), "dispatch without captured word")

endmodule

`default_nettype wire

>>> tb/ranked_score_table_top_tb.sv
`timescale 1ns / 1ps

module ranked_score_table_top_tb;

    localparam int OP_W     = rstab_pkg::OP_W;
    localparam int ID_W     = rstab_pkg::ID_W;
    localparam int SCORE_W  = rstab_pkg::SCORE_W;
    localparam int RANK_W   = rstab_pkg::RANK_W;
    localparam int STATUS_W = rstab_pkg::STATUS_W;
    localparam int TOTAL_W  = rstab_pkg::TOTAL_W;

    localparam logic [OP_W-1:0]     OP_INSERT    = rstab_pkg::OP_INSERT;
    localparam logic [OP_W-1:0]     OP_QUERY     = rstab_pkg::OP_QUERY;
    localparam logic [OP_W-1:0]     OP_DELETE    = rstab_pkg::OP_DELETE;
    localparam logic [STATUS_W-1:0] STATUS_OK    = rstab_pkg::STATUS_OK;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = rstab_pkg::STATUS_FULL;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = rstab_pkg::STATUS_RANGE;

    localparam int TABLE_DEPTH = rstab_pkg::TABLE_DEPTH_DEF;
    // run is cut off here, several times the slowest legal run
    localparam int CYCLE_LIMIT = 4000000;
    // the block answers this op code with an OK result and leaves the table alone
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam logic [ID_W-1:0] ID_MAX = '1;
    // popular scores, so that ties and multi-record deletes are common
    localparam logic [SCORE_W-1:0] SCORE_POOL [8] = '{
        16'h0000, 16'h0001, 16'h00ff, 16'h1234, 16'h7fff, 16'h8000, 16'hfffe, 16'hffff
    };

    // one input word, one field per port
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic [RANK_W-1:0]  rank;
        logic [SCORE_W-1:0] key;
    } word_t;

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     fid;
        logic [SCORE_W-1:0]  fscore;
        logic [TOTAL_W-1:0]  removed;
        logic [TOTAL_W-1:0]  total;
    } report_t;

    // directed row: word, whether the result is typed in, and that result
    typedef struct packed {
        word_t   word;
        logic    chk;
        report_t rep;
    } dir_row_t;

    typedef enum logic [1:0] {
        SEG_FILL,
        SEG_MIX,
        SEG_DRAIN
    } seg_kind_t;

    // directed part, starting from an empty table
    localparam dir_row_t DIRECTED [25] = '{
        // empty table: query, delete and the spare op
        '{'{OP_QUERY,  '0, '0, 9'd1, '0}, 1'b1, '{STATUS_RANGE, '0, '0, '0, 9'd0}},
        '{'{OP_DELETE, '0, '0, '0, 16'd5}, 1'b1, '{STATUS_OK, '0, '0, 9'd0, 9'd0}},
        '{'{OP_SPARE,  '0, '0, '0, '0}, 1'b1, '{STATUS_OK, '0, '0, '0, 9'd0}},
        // extremes of id and score
        '{'{OP_INSERT, '0, '0, '0, '0}, 1'b1, '{STATUS_OK, '0, '0, '0, 9'd1}},
        '{'{OP_INSERT, ID_MAX, 16'hffff, '0, '0}, 1'b1, '{STATUS_OK, '0, '0, '0, 9'd2}},
        // equal scores, one with an equal id too
        '{'{OP_INSERT, 31'd100, 16'd1000, '0, '0}, 1'b1, '{STATUS_OK, '0, '0, '0, 9'd3}},
        '{'{OP_INSERT, 31'd100, 16'd1000, '0, '0}, 1'b1, '{STATUS_OK, '0, '0, '0, 9'd4}},
        '{'{OP_INSERT, 31'd50, 16'd1000, '0, '0}, 1'b1, '{STATUS_OK, '0, '0, '0, 9'd5}},
        '{'{OP_INSERT, 31'd200, 16'd1000, '0, '0}, 1'b1, '{STATUS_OK, '0, '0, '0, 9'd6}},
        // first and last rank, rank zero and one past the end
        '{'{OP_QUERY, '0, '0, 9'd1, '0}, 1'b1, '{STATUS_OK, ID_MAX, 16'hffff, '0, 9'd6}},
        '{'{OP_QUERY, '0, '0, 9'd0, '0}, 1'b1, '{STATUS_RANGE, '0, '0, '0, 9'd6}},
        '{'{OP_QUERY, '0, '0, 9'd6, '0}, 1'b1, '{STATUS_OK, '0, '0, '0, 9'd6}},
        '{'{OP_QUERY, '0, '0, 9'd7, '0}, 1'b1, '{STATUS_RANGE, '0, '0, '0, 9'd6}},
        // tie order inside the score-1000 group, then a rank far past the end
        '{'{OP_QUERY, '0, '0, 9'd2, '0}, 1'b0, '0},
        '{'{OP_QUERY, '0, '0, 9'd4, '0}, 1'b0, '0},
        '{'{OP_QUERY, '0, '0, 9'd5, '0}, 1'b0, '0},
        '{'{OP_QUERY, '0, '0, 9'd256, '0}, 1'b1, '{STATUS_RANGE, '0, '0, '0, 9'd6}},
        // delete a whole group of equal scores
        '{'{OP_DELETE, '0, '0, '0, 16'd1000}, 1'b1, '{STATUS_OK, '0, '0, 9'd4, 9'd2}},
        '{'{OP_QUERY, '0, '0, 9'd2, '0}, 1'b1, '{STATUS_OK, '0, '0, '0, 9'd2}},
        '{'{OP_INSERT, 31'h55555555, 16'h8000, '0, '0}, 1'b0, '0},
        '{'{OP_INSERT, 31'h2aaaaaaa, 16'h7fff, '0, '0}, 1'b0, '0},
        '{'{OP_DELETE, '0, '0, '0, 16'hffff}, 1'b0, '0},
        // spare op with id, score and key at their top
        '{'{OP_SPARE, ID_MAX, 16'hffff, 9'd256, 16'hffff}, 1'b1,
          '{STATUS_OK, '0, '0, '0, 9'd3}},
        '{'{OP_DELETE, '0, '0, '0, 16'h0000}, 1'b0, '0},
        '{'{OP_QUERY, '0, '0, 9'd1, '0}, 1'b0, '0}
    };

    // random part: segments that fill, mix and drain the table
    localparam seg_kind_t SEG_PLAN [7] = '{
        SEG_FILL, SEG_MIX, SEG_DRAIN, SEG_FILL, SEG_MIX, SEG_DRAIN, SEG_MIX
    };
    localparam int SEG_SIZE [7] = '{320, 300, 200, 320, 300, 200, 260};

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_op;
    logic [ID_W-1:0]     s_record_id;
    logic [SCORE_W-1:0]  s_record_score;
    logic [RANK_W-1:0]   s_query_rank;
    logic [SCORE_W-1:0]  s_key_score;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [ID_W-1:0]     m_found_id;
    logic [SCORE_W-1:0]  m_found_score;
    logic [TOTAL_W-1:0]  m_removed_count;
    logic [TOTAL_W-1:0]  m_entry_total;

    // typed-in result travels alongside the word on the input side
    logic    word_chk;
    report_t word_typed;

    // shadow copy of the ordered table
    rstab_pkg::entry_t ranked [TABLE_DEPTH];
    int      held_count = 0;

    report_t pending_reports [$];
    int      mismatch_count = 0;
    int      reports_seen = 0;
    int      cycle_count = 0;
    bit      src_burst = 1'b0;

    ranked_score_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_record_id(s_record_id),
        .s_record_score(s_record_score),
        .s_query_rank(s_query_rank),
        .s_key_score(s_key_score),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_found_id(m_found_id),
        .m_found_score(m_found_score),
        .m_removed_count(m_removed_count),
        .m_entry_total(m_entry_total)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // apply one word to the shadow table and return the result it gives
    function automatic report_t rank_table_apply(input word_t w);
        report_t rep;
        int      pos;
        int      kept;
        int      gone;
        rep = '0;
        case (w.op)
            OP_INSERT: begin
                if (held_count >= TABLE_DEPTH) begin
                    rep.status = STATUS_FULL;
                end else begin
                    // walk past every record that stays ahead of the new one
                    pos = 0;
                    while (pos < held_count && (ranked[pos].score > w.score ||
                           (ranked[pos].score == w.score && ranked[pos].id < w.id)))
                        pos++;
                    for (int i = held_count; i > pos; i--)
                        ranked[i] = ranked[i - 1];
                    ranked[pos].id = w.id;
                    ranked[pos].score = w.score;
                    held_count++;
                end
            end
            OP_QUERY: begin
                if (w.rank == 0 || int'(w.rank) > held_count) begin
                    rep.status = STATUS_RANGE;
                end else begin
                    rep.fid = ranked[w.rank - 1].id;
                    rep.fscore = ranked[w.rank - 1].score;
                end
            end
            OP_DELETE: begin
                // compact forward, dropping every record with the key score
                kept = 0;
                gone = 0;
                for (int i = 0; i < held_count; i++) begin
                    if (ranked[i].score == w.key) begin
                        gone++;
                    end else begin
                        ranked[kept] = ranked[i];
                        kept++;
                    end
                end
                held_count = kept;
                rep.removed = TOTAL_W'(gone);
            end
            default: ;
        endcase
        rep.total = TOTAL_W'(held_count);
        return rep;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [SCORE_W-1:0] pick_score();
        if ($urandom_range(0, 99) < 65)
            return SCORE_POOL[$urandom_range(0, 7)];
        return SCORE_W'($urandom);
    endfunction

    // random word shaped by the kind of segment and the table fill
    function automatic word_t make_word(input seg_kind_t kind);
        word_t w;
        int    r;
        int    hi;
        w.op = OP_SPARE;
        w.id = ID_W'($urandom);
        w.score = SCORE_W'($urandom);
        w.rank = RANK_W'($urandom_range(0, TABLE_DEPTH));
        w.key = SCORE_W'($urandom);
        r = $urandom_range(0, 99);
        case (kind)
            SEG_FILL:
                w.op = (r < 93) ? OP_INSERT : (r < 99) ? OP_QUERY : OP_SPARE;
            SEG_MIX:
                w.op = (r < 40) ? OP_INSERT : (r < 72) ? OP_QUERY :
                       (r < 98) ? OP_DELETE : OP_SPARE;
            default:
                w.op = (r < 12) ? OP_INSERT : (r < 45) ? OP_QUERY :
                       (r < 99) ? OP_DELETE : OP_SPARE;
        endcase
        r = $urandom_range(0, 99);
        case (w.op)
            OP_INSERT: begin
                w.score = pick_score();
                // small and near-max ids give ties on id as well
                if (r < 30)
                    w.id = ID_W'($urandom_range(0, 15));
                else if (r < 45)
                    w.id = ID_MAX - ID_W'($urandom_range(0, 15));
            end
            OP_QUERY: begin
                hi = (held_count < TABLE_DEPTH) ? held_count + 1 : TABLE_DEPTH;
                if (r < 75)
                    w.rank = RANK_W'($urandom_range(1, hi));
                else if (r < 85)
                    w.rank = '0;
                else if (r < 92)
                    w.rank = RANK_W'(TABLE_DEPTH);
            end
            OP_DELETE: begin
                if (r < 65)
                    w.key = pick_score();
                else if (r < 85 && held_count > 0)
                    w.key = ranked[$urandom_range(0, held_count - 1)].score;
            end
            default: ;
        endcase
        return w;
    endfunction

    // drive one word from a falling edge, hold it until taken
    task automatic offer_word(input word_t w, input logic chk, input report_t typed);
        int gap;
        gap = src_burst ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= w.op;
        s_record_id <= w.id;
        s_record_score <= w.score;
        s_query_rank <= w.rank;
        s_key_score <= w.key;
        word_chk <= chk;
        word_typed <= typed;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // sender stops until every expected result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (pending_reports.size() != 0);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 40)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, fname, want, got);
        end
    endtask

    // input side: every accepted word goes through the shadow table
    always @(posedge aclk) begin : word_monitor
        word_t   w;
        report_t rep;
        if (aresetn && s_valid && s_ready) begin
            w.op = s_op;
            w.id = s_record_id;
            w.score = s_record_score;
            w.rank = s_query_rank;
            w.key = s_key_score;
            rep = rank_table_apply(w);
            // directed rows with a typed-in result use that one instead
            if (word_chk)
                pending_reports.push_back(word_typed);
            else
                pending_reports.push_back(rep);
        end
    end

    // result side: compare against the oldest expectation
    always @(posedge aclk) begin : report_monitor
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 40)
                    $display("%0t ns: stray result word, expected none, actual %0h",
                             $time, {m_status, m_found_id, m_found_score,
                                     m_removed_count, m_entry_total});
            end else begin
                want = pending_reports.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("found_id", 32'(want.fid), 32'(m_found_id));
                check_field("found_score", 32'(want.fscore), 32'(m_found_score));
                check_field("removed_count", 32'(want.removed), 32'(m_removed_count));
                check_field("entry_total", 32'(want.total), 32'(m_entry_total));
            end
        end
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    initial begin : result_sink
        int stall;
        int ticks;
        bit held_off;
        bit sink_burst;
        m_ready = 1'b0;
        ticks = 0;
        held_off = 1'b0;
        sink_burst = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            ticks++;
            if (ticks % 300 == 0)
                sink_burst = ($urandom_range(0, 3) == 0);
            if (!held_off && reports_seen >= 450) begin
                // long hold-off while the sender keeps going: block backs up
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (500) @(negedge aclk);
            end else if (sink_burst) begin
                m_ready <= 1'b1;
            end else begin
                stall = gap_len();
                if (stall == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        report_t none;
        none = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = '0;
        s_record_id = '0;
        s_record_score = '0;
        s_query_rank = '0;
        s_key_score = '0;
        word_chk = 1'b0;
        word_typed = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rows
        foreach (DIRECTED[i])
            offer_word(DIRECTED[i].word, DIRECTED[i].chk, DIRECTED[i].rep);

        // random segments, each started from a drained pipeline
        for (int s = 0; s < 7; s++) begin
            wait_drained();
            for (int n = 0; n < SEG_SIZE[s]; n++) begin
                if (n % 64 == 0)
                    src_burst = ($urandom_range(0, 3) == 0);
                offer_word(make_word(SEG_PLAN[s]), 1'b0, none);
            end
        end

        // let the last results out, then watch for strays
        wait_drained();
        repeat (300) @(negedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
